>>> src/gab_pkg.sv
package gab_pkg;

  // atlas geometry: the grid is fixed, the cell size is a top-level parameter
  localparam int GRID_CELLS    = 16;
  localparam int CELL_SIZE_DEF = 16;

  // signed width of atlas row and column math, enough for cell sizes up to 32
  // (row spans -254 .. 991 at the largest cell size)
  localparam int COORD_W = 12;

  // stream widths
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USER_W = 2;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_FONT_XMIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FONT_XMAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FONT_YMIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FONT_YMAX = 2'd3;

  // one decoded glyph byte, ready for pixel expansion
  typedef struct packed {
    logic               rejected;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [7:0]         mask;  // bit b set: pixel b from the left is written
  } gab_item_t;

  // one atlas write result
  typedef struct packed {
    logic [15:0] pixel_address;
    logic        out_of_atlas;
    logic        font_rejected;
    logic        last_write;
  } gab_result_t;

endpackage

>>> src/glyph_atlas_blit_expander_core.sv
// channel  dir  handshake                  payload
// s_axis   in   s_axis_tvalid/tready       tdata: glyph byte fields
// m_axis   out  m_axis_tvalid/tready       tdata: address, tuser: flags, tlast
// cfg      in   cfg_we (no wait)           cfg_index, cfg_data
//
// each accepted word yields n atlas writes (0..8), n being its result count;
// the single result register sends one atlas write per cycle while m_axis is not stalled.
// a word with no results frees the slot in the next cycle; a font reject frees it once its single result is sent.
// rst is synchronous; font registers clear to zero.
// a stall on m_axis holds the result register and back-pressures s_axis.
module glyph_atlas_blit_expander_core #(
  parameter int CELL_SIZE = gab_pkg::CELL_SIZE_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // char_code, glyph_width, glyph_xorig, glyph_yorig, glyph_row,
  // byte_in_row, bitmap_byte, zero fill
  input  logic [gab_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // pixel_address
  output logic [gab_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // out_of_atlas, font_rejected
  output logic [gab_pkg::OUT_USER_W-1:0]    m_axis_tuser,
  output logic                              m_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_we,
  input  logic [gab_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gab_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [7:0] font_xmin;
  logic [7:0] font_xmax;
  logic [7:0] font_ymin;
  logic [7:0] font_ymax;

  gab_pkg::gab_item_t   item;
  gab_pkg::gab_result_t result;

  // font box registers
  always_ff @(posedge clk) begin
    if (rst) begin
      font_xmin <= 8'd0;
      font_xmax <= 8'd0;
      font_ymin <= 8'd0;
      font_ymax <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gab_pkg::REG_FONT_XMIN: font_xmin <= cfg_data;
        gab_pkg::REG_FONT_XMAX: font_xmax <= cfg_data;
        gab_pkg::REG_FONT_YMIN: font_ymin <= cfg_data;
        gab_pkg::REG_FONT_YMAX: font_ymax <= cfg_data;
        default: ;
      endcase
    end
  end

  // input word decode
  gab_decode #(
    .CELL_SIZE (CELL_SIZE)
  ) u_decode (
    .font_xmin   (font_xmin),
    .font_xmax   (font_xmax),
    .font_ymin   (font_ymin),
    .font_ymax   (font_ymax),
    .char_code   (s_axis_tdata[7:0]),
    .glyph_width (s_axis_tdata[15:8]),
    .glyph_xorig (s_axis_tdata[23:16]),
    .glyph_yorig (s_axis_tdata[31:24]),
    .glyph_row   (s_axis_tdata[39:32]),
    .byte_in_row (s_axis_tdata[44:40]),
    .bitmap_byte (s_axis_tdata[52:45]),
    .item        (item)
  );

  // pixel expansion and result register
  gab_emit #(
    .CELL_SIZE (CELL_SIZE)
  ) u_emit (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (item),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_result (result)
  );

  // output word packing
  assign m_axis_tdata = result.pixel_address;
  assign m_axis_tuser = {result.font_rejected, result.out_of_atlas};
  assign m_axis_tlast = result.last_write;

endmodule

>>> src/gab_decode.sv
module gab_decode #(
  parameter int CELL_SIZE = gab_pkg::CELL_SIZE_DEF
) (
  input  logic [7:0]         font_xmin,
  input  logic [7:0]         font_xmax,
  input  logic [7:0]         font_ymin,
  input  logic [7:0]         font_ymax,
  input  logic [7:0]         char_code,
  input  logic [7:0]         glyph_width,
  input  logic [7:0]         glyph_xorig,
  input  logic [7:0]         glyph_yorig,
  input  logic [7:0]         glyph_row,
  input  logic [4:0]         byte_in_row,
  input  logic [7:0]         bitmap_byte,
  output gab_pkg::gab_item_t item
);

  localparam int CW = gab_pkg::COORD_W;
  localparam logic signed [8:0] CellLim = 9'(CELL_SIZE);

  logic signed [8:0] font_w;
  logic signed [8:0] font_h;
  logic [3:0]        cell_x;
  logic [3:0]        cell_y;

  always_comb begin
    // font box size check, signed differences
    font_w = $signed({font_xmax[7], font_xmax}) - $signed({font_xmin[7], font_xmin});
    font_h = $signed({font_ymax[7], font_ymax}) - $signed({font_ymin[7], font_ymin});
    item.rejected = (font_w >= CellLim) || (font_h >= CellLim);

    // cell selection and base coordinates, modular in CW bits
    cell_x = char_code[3:0];
    cell_y = char_code[7:4];
    item.row = CW'(cell_y) * CW'(CELL_SIZE) + CW'(glyph_row)
             - CW'($signed(font_ymin)) - CW'($signed(glyph_yorig));
    item.col = CW'(cell_x) * CW'(CELL_SIZE) + CW'({byte_in_row, 3'b000})
             - CW'($signed(glyph_xorig));

    // set pixels that lie inside the glyph width
    for (int b = 0; b < 8; b++) begin
      item.mask[b] = bitmap_byte[7-b] && ({byte_in_row, 3'(b)} < glyph_width);
    end
  end

endmodule

>>> src/gab_emit.sv
module gab_emit #(
  parameter int CELL_SIZE = gab_pkg::CELL_SIZE_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  gab_pkg::gab_item_t    in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output gab_pkg::gab_result_t  out_result
);

  localparam int CW        = gab_pkg::COORD_W;
  localparam int ATLAS_DIM = CELL_SIZE * gab_pkg::GRID_CELLS;

  // work register: the byte being expanded
  logic               work_valid;
  gab_pkg::gab_item_t work;

  logic [2:0]           idx;
  logic [7:0]           low_bit;
  logic [7:0]           remaining;
  logic [CW-1:0]        col;
  logic                 oob;
  logic                 emit;
  logic                 done;
  logic                 in_take;
  gab_pkg::gab_result_t result_next;

  // leftmost pending pixel
  always_comb begin
    idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (work.mask[i]) begin
        idx = 3'(i);
      end
    end
    low_bit   = work.mask & (~work.mask + 8'd1);
    remaining = work.mask & ~low_bit;
  end

  // atlas address of that pixel
  always_comb begin
    col = work.col + CW'(idx);
    oob = work.row[CW-1] || (work.row >= CW'(ATLAS_DIM))
       || col[CW-1] || (col >= CW'(ATLAS_DIM));
    result_next.pixel_address = 16'd0;
    result_next.out_of_atlas  = 1'b0;
    result_next.font_rejected = 1'b0;
    result_next.last_write    = 1'b1;
    if (!work.rejected) begin
      result_next.out_of_atlas = oob;
      result_next.last_write   = (remaining == 8'd0);
      if (!oob) begin
        result_next.pixel_address = 16'(work.row) * 16'(ATLAS_DIM) + 16'(col);
      end
    end else begin
      result_next.font_rejected = 1'b1;
    end
  end

  // handshake
  always_comb begin
    emit     = work_valid && (!out_valid || out_ready);
    done     = emit && (work.rejected || (remaining == 8'd0));
    in_ready = !work_valid || done;
    in_take  = in_valid && in_ready;
  end

  // work register control
  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
    end else if (in_take) begin
      // a byte that is not rejected and has no qualifying pixel produces nothing
      work_valid <= in_item.rejected || (in_item.mask != 8'd0);
    end else if (done) begin
      work_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      work <= in_item;
    end else if (emit) begin
      work.mask <= remaining;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_result <= result_next;
    end
  end

endmodule

>>> bench/tb_glyph_atlas_blit_expander_core.sv
module tb_glyph_atlas_blit_expander_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELL       = gab_pkg::CELL_SIZE_DEF;
  localparam int ATLAS      = CELL * gab_pkg::GRID_CELLS;
  localparam int RAND_WORDS = 410;
  localparam int SETTLE     = 12;
  localparam int STUCK_MAX  = 3000;

  // expected atlas writes and the font box they are computed under
  class atlas_write_board;
    gab_pkg::gab_result_t pending_writes[$];
    logic signed [7:0]    font_box[4];
    int                   failures;

    function new();
      failures = 0;
      foreach (font_box[i]) font_box[i] = '0;
    endfunction

    function void set_font_reg(logic [gab_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
      case (idx)
        gab_pkg::REG_FONT_XMIN: font_box[0] = val;
        gab_pkg::REG_FONT_XMAX: font_box[1] = val;
        gab_pkg::REG_FONT_YMIN: font_box[2] = val;
        gab_pkg::REG_FONT_YMAX: font_box[3] = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_writes.size();
    endfunction

    // expand one glyph byte into its atlas writes
    function void note_glyph_byte(logic [gab_pkg::IN_DATA_W-1:0] d);
      int                   box_w, box_h, gw, xo, yo, grow, bidx, code, row, col, x, n;
      logic [7:0]           bits;
      logic                 oob;
      gab_pkg::gab_result_t batch[8];
      gab_pkg::gab_result_t r;
      box_w = int'(font_box[1]) - int'(font_box[0]);
      box_h = int'(font_box[3]) - int'(font_box[2]);
      code  = int'(d[7:0]);
      gw    = int'(d[15:8]);
      xo    = int'($signed(d[23:16]));
      yo    = int'($signed(d[31:24]));
      grow  = int'(d[39:32]);
      bidx  = int'(d[44:40]);
      bits  = d[52:45];
      // oversized font box gives a single reject
      if (box_w >= CELL || box_h >= CELL) begin
        r = '{pixel_address: 16'h0, out_of_atlas: 1'b0, font_rejected: 1'b1,
              last_write: 1'b1};
        pending_writes.push_back(r);
        return;
      end
      row = (code / gab_pkg::GRID_CELLS) * CELL + grow - int'(font_box[2]) - yo;
      n = 0;
      for (int b = 0; b < 8; b++) begin
        x = bidx * 8 + b;
        if (x < gw && bits[7-b]) begin
          col = (code % gab_pkg::GRID_CELLS) * CELL + x - xo;
          oob = (row < 0 || row >= ATLAS || col < 0 || col >= ATLAS);
          batch[n].pixel_address = oob ? 16'h0 : 16'(row * ATLAS + col);
          batch[n].out_of_atlas  = oob;
          batch[n].font_rejected = 1'b0;
          batch[n].last_write    = 1'b0;
          n++;
        end
      end
      for (int k = 0; k < n; k++) begin
        r = batch[k];
        r.last_write = (k == n - 1);
        pending_writes.push_back(r);
      end
    endfunction

    // compare one accepted write with the oldest expectation
    function void check_atlas_write(gab_pkg::gab_result_t got);
      gab_pkg::gab_result_t want;
      if (pending_writes.size() == 0) begin
        $error("unexpected write: pixel_address %0d", got.pixel_address);
        failures++;
        return;
      end
      want = pending_writes.pop_front();
      if (got.pixel_address !== want.pixel_address) begin
        $error("pixel_address expected %0d got %0d", want.pixel_address,
               got.pixel_address);
        failures++;
      end
      if (got.out_of_atlas !== want.out_of_atlas) begin
        $error("out_of_atlas expected %0d got %0d", want.out_of_atlas, got.out_of_atlas);
        failures++;
      end
      if (got.font_rejected !== want.font_rejected) begin
        $error("font_rejected expected %0d got %0d", want.font_rejected,
               got.font_rejected);
        failures++;
      end
      if (got.last_write !== want.last_write) begin
        $error("last_write expected %0d got %0d", want.last_write, got.last_write);
        failures++;
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst;
  logic [gab_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [gab_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [gab_pkg::OUT_USER_W-1:0] m_axis_tuser;
  logic                           m_axis_tlast;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic                           cfg_we;
  logic [gab_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [gab_pkg::CFG_DATA_W-1:0] cfg_data;

  atlas_write_board board = new();
  int send_idle_pct = 9;
  int recv_idle_pct = 74;
  int stuck_cycles  = 0;

  glyph_atlas_blit_expander_core dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // atlas write side: random stalls and checking
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      board.check_atlas_write('{pixel_address: m_axis_tdata,
                                out_of_atlas: m_axis_tuser[0],
                                font_rejected: m_axis_tuser[1],
                                last_write: m_axis_tlast});
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_MAX) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [gab_pkg::IN_DATA_W-1:0] pack_glyph(
    int code, int gw, int xo, int yo, int grow, int bidx, int bits);
    return {3'b000, 8'(bits), 5'(bidx), 8'(grow), 8'(yo), 8'(xo), 8'(gw), 8'(code)};
  endfunction

  // mostly well-placed glyph bytes, some out of place, some pure noise
  function automatic logic [gab_pkg::IN_DATA_W-1:0] random_glyph();
    int gw, bidx, xo, yo, grow;
    if ($urandom_range(9) == 0) begin
      return pack_glyph($urandom_range(255), $urandom_range(255), $urandom_range(255),
                        $urandom_range(255), $urandom_range(255), $urandom_range(31),
                        $urandom_range(255));
    end
    bidx = $urandom_range(31);
    if ($urandom_range(1) == 0) begin
      gw = bidx * 8 + $urandom_range(9);
      if (gw > 255) gw = 255;
    end else begin
      gw = $urandom_range(255);
      bidx = $urandom_range(3) == 0 ? $urandom_range(31) : $urandom_range(1);
    end
    xo   = $urandom_range(4) == 0 ? $urandom_range(255) : int'($urandom_range(16)) - 8;
    yo   = $urandom_range(4) == 0 ? $urandom_range(255) : int'($urandom_range(16)) - 8;
    grow = $urandom_range(5) == 0 ? $urandom_range(255) : $urandom_range(15);
    return pack_glyph($urandom_range(255), gw, xo, yo, grow, bidx, $urandom_range(255));
  endfunction

  // one glyph byte onto the input stream
  task automatic send_glyph(logic [gab_pkg::IN_DATA_W-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tdata  <= d;
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.note_glyph_byte(d);
  endtask

  // hold the input until every expected write is out, then let the core settle
  task automatic drain_writes();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [gab_pkg::CFG_IDX_W-1:0] idx, int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 8'(val);
    @(posedge clk);
    board.set_font_reg(idx, 8'(val));
  endtask

  task automatic set_font(int xmin, int xmax, int ymin, int ymax);
    drain_writes();
    write_reg(gab_pkg::REG_FONT_XMIN, xmin);
    write_reg(gab_pkg::REG_FONT_XMAX, xmax);
    write_reg(gab_pkg::REG_FONT_YMIN, ymin);
    write_reg(gab_pkg::REG_FONT_YMAX, ymax);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int sent;
    int phase_len;
    int xmin, ymin;
    rst           <= 1'b1;
    s_axis_tdata  <= '0;
    s_axis_tvalid <= 1'b0;
    m_axis_tready <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= gab_pkg::REG_FONT_XMIN;
    cfg_data      <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: reset font box, full and partial rows, edges of the atlas
    send_glyph(pack_glyph(0, 8, 0, 0, 0, 0, 8'hFF));
    send_glyph(pack_glyph(0, 8, 0, 0, 0, 0, 8'h00));
    send_glyph(pack_glyph(1, 1, 0, 0, 3, 0, 8'h80));
    send_glyph(pack_glyph(2, 0, 0, 0, 0, 0, 8'hFF));
    send_glyph(pack_glyph(3, 5, 0, 0, 1, 0, 8'hFF));
    send_glyph(pack_glyph(255, 255, 0, 0, 255, 31, 8'hFF));
    send_glyph(pack_glyph(0, 16, 127, 0, 0, 1, 8'hAA));
    send_glyph(pack_glyph(0, 8, 0, 127, 0, 0, 8'h0F));
    send_glyph(pack_glyph(15, 8, -128, 0, 2, 0, 8'hC3));
    send_glyph(pack_glyph(240, 8, 0, -128, 255, 0, 8'h55));
    send_glyph(pack_glyph(8'h37, 12, -1, 1, 7, 1, 8'hF0));

    // width at the reject limit, height just below it
    set_font(-8, 8, -3, 12);
    send_glyph(pack_glyph(65, 8, 0, 0, 0, 0, 8'hFF));
    send_glyph(pack_glyph(65, 8, 0, 0, 0, 0, 8'h00));
    // height far over the limit
    set_font(-1, 10, -128, 127);
    send_glyph(pack_glyph(66, 8, 0, 0, 0, 0, 8'h81));
    // inverted boxes at the register extremes
    set_font(127, -128, 127, -128);
    send_glyph(pack_glyph(17, 8, 0, 0, 200, 0, 8'hFF));
    send_glyph(pack_glyph(200, 8, 0, 0, 0, 0, 8'h3C));
    // widest accepted box, largest baseline
    set_font(-128, -113, -128, -128);
    send_glyph(pack_glyph(5, 8, 0, 0, 0, 0, 8'hFF));
    send_glyph(pack_glyph(5, 8, 0, 127, 0, 0, 8'h99));
    set_font(-1, 10, -3, 12);
    send_glyph(pack_glyph(77, 16, 2, -2, 5, 1, 8'h7E));

    // random phases, each with its own font box
    sent = 0;
    while (sent < RAND_WORDS) begin
      if ($urandom_range(5) == 0) begin
        set_font($urandom_range(255), $urandom_range(255), $urandom_range(255),
                 $urandom_range(255));
      end else begin
        xmin = -int'($urandom_range(10));
        ymin = -int'($urandom_range(10));
        set_font(xmin, xmin + $urandom_range(15), ymin, ymin + $urandom_range(15));
      end
      phase_len = $urandom_range(20, 50);
      for (int i = 0; i < phase_len && sent < RAND_WORDS; i++) begin
        if (sent < RAND_WORDS / 3) begin
          send_idle_pct = 9;
          recv_idle_pct = 74;
        end else if (sent < 2 * RAND_WORDS / 3) begin
          send_idle_pct = 74;
          recv_idle_pct = 9;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        send_glyph(random_glyph());
        sent++;
        if ($urandom_range(39) == 0) drain_writes();
      end
    end

    // wind down and report
    drain_writes();
    if (board.failures == 0 && board.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
